// ----- rtl/mha_pkg.sv -----
// Package: shared constants, arctangent table and sideband types for the heading block.
package mha_pkg;
    localparam int ANGLE_W     = 30;  // signed z, units of 2^-20 degree
    localparam int ANGLE_FRAC  = 20;
    localparam int OUT_W       = 16;
    localparam int TABLE_LEN   = 24;
    localparam logic [OUT_W-1:0] FULL_TURN = 16'd46080;
    localparam logic signed [ANGLE_W-1:0] Z_90  = 30'sd94371840;
    localparam logic signed [ANGLE_W-1:0] Z_180 = 30'sd188743680;

    // Flags that travel beside the data through every stage.
    typedef struct packed {
        logic zero_col;
        logic mirror;
        logic neg_x;
    } t_side;

    function automatic logic signed [ANGLE_W-1:0] atan_deg(input logic [4:0] idx);
        logic signed [ANGLE_W-1:0] v;
        case (idx)
            5'd0:    v = 30'sd47185920;
            5'd1:    v = 30'sd27855475;
            5'd2:    v = 30'sd14718068;
            5'd3:    v = 30'sd7471121;
            5'd4:    v = 30'sd3750058;
            5'd5:    v = 30'sd1876857;
            5'd6:    v = 30'sd938658;
            5'd7:    v = 30'sd469357;
            5'd8:    v = 30'sd234682;
            5'd9:    v = 30'sd117342;
            5'd10:   v = 30'sd58671;
            5'd11:   v = 30'sd29335;
            5'd12:   v = 30'sd14668;
            5'd13:   v = 30'sd7334;
            5'd14:   v = 30'sd3667;
            5'd15:   v = 30'sd1833;
            5'd16:   v = 30'sd917;
            5'd17:   v = 30'sd458;
            5'd18:   v = 30'sd229;
            5'd19:   v = 30'sd115;
            5'd20:   v = 30'sd57;
            5'd21:   v = 30'sd29;
            5'd22:   v = 30'sd14;
            5'd23:   v = 30'sd7;
            default: v = '0;
        endcase
        return v;
    endfunction
endpackage

// ----- rtl/mha_in_if.sv -----
// Interface: input channel carrying one matrix column.
interface mha_in_if #(parameter int W = 16);
    logic         valid;
    logic         ready;
    logic [W-1:0] r_one_one;
    logic [W-1:0] r_two_one;
    logic [W-1:0] r_three_one;
    modport source(output valid, r_one_one, r_two_one, r_three_one, input ready);
    modport sink(input valid, r_one_one, r_two_one, r_three_one, output ready);
endinterface

// ----- rtl/mha_out_if.sv -----
// Interface: output channel carrying one heading result.
interface mha_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] heading_degrees;
    logic        invalid;
    modport source(output valid, heading_degrees, invalid, input ready);
    modport sink(input valid, heading_degrees, invalid, output ready);
endinterface

// ----- rtl/mha_sqrt_stage.sv -----
// One pipelined restoring square-root step (two radicand bits per stage).
module mha_sqrt_stage
    import mha_pkg::*;
#(
    parameter int RW    = 64,   // radicand width
    parameter int QW    = 32,   // root width
    parameter int STEP  = 0,    // 0 = most significant digit
    parameter int PW    = 40    // passthrough width
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [RW-1:0] i_rem,
    input  logic [QW-1:0] i_root,
    input  logic [PW-1:0] i_pass,
    output logic          o_valid,
    output logic [RW-1:0] o_rem,
    output logic [QW-1:0] o_root,
    output logic [PW-1:0] o_pass
);
    localparam int SH = 2 * (QW - 1 - STEP);

    logic [RW-1:0] n_rem;
    logic [QW-1:0] n_root;
    logic [RW+1:0] trial;
    logic [RW+1:0] rem_hi;

    always_comb begin
        // trial = (4*root + 1) << SH, compared against the remainder
        trial  = ({{(RW+2-QW){1'b0}}, i_root} << (SH + 2)) | ((RW+2)'(1) << SH);
        rem_hi = {2'b00, i_rem};
        if (rem_hi >= trial) begin
            n_rem  = RW'(rem_hi - trial);
            n_root = {i_root[QW-2:0], 1'b1};
        end else begin
            n_rem  = i_rem;
            n_root = {i_root[QW-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
        if (i_en) begin
            o_rem  <= n_rem;
            o_root <= n_root;
            o_pass <= i_pass;
        end
    end
endmodule

// ----- rtl/mha_cordic_stage.sv -----
// One unrolled CORDIC vectoring rotation, degrees accumulator.
module mha_cordic_stage
    import mha_pkg::*;
#(
    parameter int XW   = 34,
    parameter int STEP = 0,
    parameter int PW   = 3
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_valid,
    input  logic signed [XW-1:0]      i_x,
    input  logic signed [XW-1:0]      i_y,
    input  logic signed [ANGLE_W-1:0] i_z,
    input  logic [PW-1:0]             i_pass,
    output logic                      o_valid,
    output logic signed [XW-1:0]      o_x,
    output logic signed [XW-1:0]      o_y,
    output logic signed [ANGLE_W-1:0] o_z,
    output logic [PW-1:0]             o_pass
);
    logic signed [XW-1:0]      xs, ys, n_x, n_y;
    logic signed [ANGLE_W-1:0] n_z, t;

    always_comb begin
        xs = i_x >>> STEP;
        ys = i_y >>> STEP;
        t  = atan_deg(5'(STEP));
        if (!i_y[XW-1]) begin
            n_x = i_x + ys;
            n_y = i_y - xs;
            n_z = i_z + t;
        end else begin
            n_x = i_x - ys;
            n_y = i_y + xs;
            n_z = i_z - t;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
        if (i_en) begin
            o_x    <= n_x;
            o_y    <= n_y;
            o_z    <= n_z;
            o_pass <= i_pass;
        end
    end
endmodule

// ----- rtl/matrix_heading_angle_top.sv -----
// Top level: heading angle from the first rotation-matrix column.
// The block accepts one column (r11, r21, r31) per clock while the output is not stalled
// and returns one heading in Q9.7 degrees per transfer. The pipe holds 2 + (W + E + 1) +
// min(CORDIC_STEPS, 24) + 1 register stages, with W = COMPONENT_WIDTH and E = (32 - W) / 2
// guard bits. That is 44 at the defaults. One stage forms squares and one sums them.
// W + E + 1 stages of a pipelined restoring square root give the side length, one root
// bit per stage. The unrolled vectoring stages give the angle, and a final stage clamps,
// rounds and mirrors. All stages advance together on a global enable (output register
// empty or being drained), so throughput is one transfer per cycle whenever the sink
// keeps ready high. An all-zero column yields invalid = 1.
module matrix_heading_angle_top
    import mha_pkg::*;
#(
    parameter int COMPONENT_WIDTH = 16,
    parameter int CORDIC_STEPS    = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    mha_in_if.sink    i_in,
    mha_out_if.source o_out
);
    localparam int W    = COMPONENT_WIDTH;
    localparam int E    = (32 - W) / 2;        // guard bits
    localparam int SQW  = 2 * W;               // one square
    localparam int RW   = 2 * W + 2 * E + 2;   // radicand incl. shift, with headroom
    localparam int QW   = RW / 2;              // root width
    localparam int XW   = QW + 3;              // CORDIC datapath
    localparam int NS   = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
    localparam int PW   = W + E + 3;           // |r11|<<E plus side flags

    // Whole pipe advances when the output register can take a new value.
    logic en;
    assign en = !o_out.valid || o_out.ready;
    assign i_in.ready = en;

    // Stage 1: magnitudes and squares.
    logic          r_v1;
    logic [W-1:0]  ua, ub, uc;
    logic [SQW-1:0] r_sb, r_sc;
    logic [W-1:0]  r_ua;
    t_side         r_s1, n_s1;

    always_comb begin
        ua = i_in.r_one_one[W-1]   ? W'(-i_in.r_one_one)   : i_in.r_one_one;
        ub = i_in.r_two_one[W-1]   ? W'(-i_in.r_two_one)   : i_in.r_two_one;
        uc = i_in.r_three_one[W-1] ? W'(-i_in.r_three_one) : i_in.r_three_one;
        n_s1.zero_col = (i_in.r_one_one == '0) && (i_in.r_two_one == '0)
                        && (i_in.r_three_one == '0);
        n_s1.mirror   = i_in.r_three_one[W-1];
        n_s1.neg_x    = i_in.r_one_one[W-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_in.valid;
        end
        if (en) begin
            r_sb <= SQW'({{W{1'b0}}, ub} * {{W{1'b0}}, ub});
            r_sc <= SQW'({{W{1'b0}}, uc} * {{W{1'b0}}, uc});
            r_ua <= ua;
            r_s1 <= n_s1;
        end
    end

    // Stage 2: sum of squares, scaled by 2^(2E).
    logic          r_v2;
    logic [RW-1:0] r_rad;
    logic [PW-1:0] r_p2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (en) begin
            r_v2 <= r_v1;
        end
        if (en) begin
            r_rad <= (RW'(r_sb) + RW'(r_sc)) << (2 * E);
            r_p2  <= {r_s1, {r_ua, {E{1'b0}}}};
        end
    end

    // Square root pipeline.
    logic          sq_v [QW+1];
    logic [RW-1:0] sq_r [QW+1];
    logic [QW-1:0] sq_q [QW+1];
    logic [PW-1:0] sq_p [QW+1];

    assign sq_v[0] = r_v2;
    assign sq_r[0] = r_rad;
    assign sq_q[0] = '0;
    assign sq_p[0] = r_p2;

    for (genvar g = 0; g < QW; g++) begin : g_sqrt
        mha_sqrt_stage #(.RW(RW), .QW(QW), .STEP(g), .PW(PW)) u_stage (
            .i_clk  (i_clk),   .i_rst_n(i_rst_n), .i_en(en),
            .i_valid(sq_v[g]), .i_rem(sq_r[g]),   .i_root(sq_q[g]), .i_pass(sq_p[g]),
            .o_valid(sq_v[g+1]), .o_rem(sq_r[g+1]), .o_root(sq_q[g+1]),
            .o_pass(sq_p[g+1])
        );
    end

    // CORDIC entry: quarter turn when r11 is negative.
    logic                      cd_v [NS+1];
    logic signed [XW-1:0]      cd_x [NS+1];
    logic signed [XW-1:0]      cd_y [NS+1];
    logic signed [ANGLE_W-1:0] cd_z [NS+1];
    logic [2:0]                cd_p [NS+1];
    t_side                     s_sq;
    logic signed [XW-1:0]      x0, m0;

    always_comb begin
        s_sq = t_side'(sq_p[QW][PW-1 -: 3]);
        x0   = XW'(sq_p[QW][W+E-1:0]);
        m0   = XW'(sq_q[QW]);
    end
    assign cd_v[0] = sq_v[QW];
    assign cd_x[0] = s_sq.neg_x ? m0 : x0;
    assign cd_y[0] = s_sq.neg_x ? x0 : m0;
    assign cd_z[0] = s_sq.neg_x ? Z_90 : '0;
    assign cd_p[0] = s_sq;

    for (genvar g = 0; g < NS; g++) begin : g_cordic
        mha_cordic_stage #(.XW(XW), .STEP(g), .PW(3)) u_stage (
            .i_clk  (i_clk),   .i_rst_n(i_rst_n), .i_en(en),
            .i_valid(cd_v[g]), .i_x(cd_x[g]), .i_y(cd_y[g]), .i_z(cd_z[g]),
            .i_pass (cd_p[g]),
            .o_valid(cd_v[g+1]), .o_x(cd_x[g+1]), .o_y(cd_y[g+1]), .o_z(cd_z[g+1]),
            .o_pass (cd_p[g+1])
        );
    end

    // Final stage: clamp, round to Q9.7, mirror; this is the output register.
    t_side                     s_end;
    logic signed [ANGLE_W-1:0] zc;
    logic [ANGLE_W-1:0]        zr;
    logic [OUT_W-1:0]          q, n_head;
    logic                      r_oval;
    logic [OUT_W-1:0]          r_head;
    logic                      r_inv;

    always_comb begin
        s_end = t_side'(cd_p[NS]);
        zc    = cd_z[NS];
        if (zc < 0)     zc = '0;
        if (zc > Z_180) zc = Z_180;
        zr = ($unsigned(zc) + ANGLE_W'(1 << 12)) >> 13;
        q  = zr[OUT_W-1:0];
        if (s_end.zero_col) begin
            n_head = '0;
        end else if (s_end.mirror) begin
            n_head = (q == '0) ? '0 : OUT_W'(FULL_TURN - q);
        end else begin
            n_head = q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oval <= 1'b0;
        end else if (en) begin
            r_oval <= cd_v[NS];
        end
        if (en) begin
            r_head <= n_head;
            r_inv  <= s_end.zero_col;
        end
    end

    assign o_out.valid           = r_oval;
    assign o_out.heading_degrees = r_head;
    assign o_out.invalid         = r_inv;

    // Stalled output holds its result.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.ready |=> o_out.valid && $stable(o_out.heading_degrees))
        else $error("output changed under stall");
    // Invalid results carry zero angle.
    a_inv_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.invalid |-> o_out.heading_degrees == '0)
        else $error("invalid result with nonzero angle");
    // Heading stays below a full turn.
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> o_out.heading_degrees < FULL_TURN)
        else $error("heading out of range");
endmodule

// ----- bench/matrix_heading_angle_checker.sv -----
// Checker: watches both channels, predicts each heading and compares in order.
module matrix_heading_angle_checker
    import mha_pkg::*;
#(
    parameter int COMPONENT_WIDTH = 16,
    parameter int CORDIC_STEPS    = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    mha_in_if.sink    i_in_mon,
    mha_out_if.sink   i_out_mon,
    output int        o_fail_count,
    output int        o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int GUARD = (32 - COMPONENT_WIDTH) / 2;

    typedef struct packed {
        logic [15:0] heading;
        logic        invalid;
    } t_heading;

    t_heading heading_queue[$];
    int fail_count = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = heading_queue.size();

    function automatic longint sext_comp(input logic [COMPONENT_WIDTH-1:0] v);
        return longint'($signed(v));
    endfunction

    function automatic longint floor_shift(input longint v, input int s);
        return v >>> s;
    endfunction

    function automatic longint unsigned int_root(input longint unsigned v);
        longint unsigned res, bits;
        res  = 0;
        bits = 64'd1 << 62;
        while (bits > v) bits = bits >> 2;
        while (bits != 0) begin
            if (v >= res + bits) begin
                v   = v - (res + bits);
                res = (res >> 1) + bits;
            end else begin
                res = res >> 1;
            end
            bits = bits >> 2;
        end
        return res;
    endfunction

    function automatic t_heading predict_heading(input logic [COMPONENT_WIDTH-1:0] ra,
            input logic [COMPONENT_WIDTH-1:0] rb, input logic [COMPONENT_WIDTH-1:0] rc);
        longint a, b, c, x, y, z, xs, ys;
        longint unsigned ua, ub, uc, m, q;
        t_heading h;
        a = sext_comp(ra); b = sext_comp(rb); c = sext_comp(rc);
        if (a == 0 && b == 0 && c == 0) begin
            h.heading = '0; h.invalid = 1'b1;
            return h;
        end
        ua = (a < 0) ? -a : a;
        ub = (b < 0) ? -b : b;
        uc = (c < 0) ? -c : c;
        m = int_root((ub * ub + uc * uc) << (2 * GUARD));
        if (a < 0) begin
            x = m; y = ua << GUARD; z = Z_90;
        end else begin
            x = ua << GUARD; y = m; z = 0;
        end
        for (int i = 0; i < CORDIC_STEPS && i < TABLE_LEN; i++) begin
            xs = floor_shift(x, i);
            ys = floor_shift(y, i);
            if (y >= 0) begin
                x = x + ys; y = y - xs; z = z + longint'(atan_deg(5'(i)));
            end else begin
                x = x - ys; y = y + xs; z = z - longint'(atan_deg(5'(i)));
            end
        end
        if (z < 0) z = 0;
        if (z > Z_180) z = Z_180;
        q = (z + (64'd1 << 12)) >> 13;
        if (c < 0) begin
            q = FULL_TURN - q;
            if (q >= FULL_TURN) q = 0;
        end
        h.heading = q[15:0];
        h.invalid = 1'b0;
        return h;
    endfunction

    always @(posedge i_clk) begin
        t_heading want;
        if (i_rst_n) begin
            if (i_in_mon.valid && i_in_mon.ready)
                heading_queue.push_back(predict_heading(i_in_mon.r_one_one,
                    i_in_mon.r_two_one, i_in_mon.r_three_one));
            if (i_out_mon.valid && i_out_mon.ready) begin
                if (heading_queue.size() == 0) begin
                    $error("unexpected result transfer");
                    fail_count++;
                end else begin
                    want = heading_queue.pop_front();
                    if (i_out_mon.heading_degrees !== want.heading) begin
                        $error("heading_degrees: expected %0d actual %0d",
                               want.heading, i_out_mon.heading_degrees);
                        fail_count++;
                    end
                    if (i_out_mon.invalid !== want.invalid) begin
                        $error("invalid: expected %0d actual %0d",
                               want.invalid, i_out_mon.invalid);
                        fail_count++;
                    end
                end
            end
        end
    end
endmodule

// ----- bench/matrix_heading_angle_top_test.sv -----
// Testbench top: clock, reset, column stimulus, sink stalls and the verdict.
module matrix_heading_angle_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int W         = 16;
    localparam int LATENCY   = 2 + 25 + 16 + 1;
    localparam int N_RANDOM  = 1830;
    localparam int MAX_CYCLE = 400000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   cycle = 0;
    int   fail_count;
    int   pending;
    bit   calm = 1'b0;        // last part of the run: no idling anywhere
    bit   long_hold = 1'b0;   // sink holds off while the source keeps offering

    mha_in_if #(.W(W)) in_ch();
    mha_out_if         out_ch();

    matrix_heading_angle_top #(.COMPONENT_WIDTH(W), .CORDIC_STEPS(16)) DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch.sink), .o_out(out_ch.source)
    );

    matrix_heading_angle_checker #(.COMPONENT_WIDTH(W), .CORDIC_STEPS(16)) checker_inst (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_mon(in_ch.sink), .i_out_mon(out_ch.sink),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always #2 i_clk = ~i_clk;

    // Watchdog: the slowest correct run is far below this.
    always @(posedge i_clk) begin
        cycle <= cycle + 1;
        if (cycle > MAX_CYCLE) begin
            $display("matrix_heading_angle_top_test: FAIL");
            $finish;
        end
    end

    initial begin
        in_ch.valid = 1'b0;
        in_ch.r_one_one = '0;
        in_ch.r_two_one = '0;
        in_ch.r_three_one = '0;
        out_ch.ready = 1'b0;
    end

    // Sink: random bursts of stall, one long hold-off when asked.
    initial begin
        int n;
        @(posedge i_clk);
        forever begin
            if (long_hold) begin
                out_ch.ready <= 1'b0;
                repeat (200) @(posedge i_clk);
                long_hold = 1'b0;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                out_ch.ready <= 1'b0;
                n = $urandom_range(1, 8);
                repeat (n) @(posedge i_clk);
            end else begin
                out_ch.ready <= 1'b1;
                n = $urandom_range(1, 20);
                repeat (n) @(posedge i_clk);
            end
        end
    end

    // One column transfer; valid stays high when the next one follows at once.
    task automatic send_column(input logic [W-1:0] a, input logic [W-1:0] b,
                               input logic [W-1:0] c);
        in_ch.valid       <= 1'b1;
        in_ch.r_one_one   <= a;
        in_ch.r_two_one   <= b;
        in_ch.r_three_one <= c;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    task automatic maybe_gap();
        int n;
        if (!calm && $urandom_range(0, 5) == 0) begin
            in_ch.valid <= 1'b0;
            n = $urandom_range(1, 8);
            repeat (n) @(posedge i_clk);
        end
    endtask

    function automatic logic [W-1:0] pick_comp();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return '0;
            3: return 16'(4096);       // +1.0
            4: return 16'(-4096);      // -1.0
            5: return 16'($urandom_range(0, 64)) - 16'd32;
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        logic [W-1:0] edge_vals[6];
        edge_vals = '{16'h8000, 16'h7fff, 16'h0000, 16'h0001, 16'hffff, 16'h1000};
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: zero column, columns along each axis, extremes, mirror sign.
        send_column('0, '0, '0);
        send_column(16'h1000, '0, '0);
        send_column(16'hf000, '0, '0);
        send_column('0, 16'h1000, '0);
        send_column('0, '0, 16'hf000);
        send_column('0, '0, 16'h1000);
        send_column(16'h8000, 16'h8000, 16'h8000);
        send_column(16'h7fff, 16'h7fff, 16'h7fff);
        send_column(16'h8000, 16'h7fff, 16'h8000);
        send_column(16'h0001, '0, 16'hffff);
        send_column(16'hffff, '0, 16'hffff);
        send_column(16'h0b50, 16'h0b50, 16'hffff);  // tiny negative r31 with r11 = r21, near 45 degrees
        send_column(16'h1000, '0, 16'hffff);         // small angle mirrored to just below a full turn
        for (int i = 0; i < 6; i++)
            send_column(edge_vals[i], edge_vals[5 - i], edge_vals[(i + 2) % 6]);

        // Random columns; the sink holds off once early on, the source once waits for the pipe to drain.
        for (int k = 0; k < N_RANDOM; k++) begin
            if (k == 400) long_hold = 1'b1;
            if (k == 900) begin
                in_ch.valid <= 1'b0;
                @(posedge i_clk);
                while (pending != 0) @(posedge i_clk);
            end
            if (k == N_RANDOM - 200) calm = 1'b1;
            maybe_gap();
            send_column(pick_comp(), pick_comp(), pick_comp());
        end
        in_ch.valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (fail_count == 0)
            $display("matrix_heading_angle_top_test: PASS");
        else
            $display("matrix_heading_angle_top_test: FAIL");
        $finish;
    end
endmodule

// ----- files.f -----
rtl/mha_pkg.sv
rtl/mha_in_if.sv
rtl/mha_out_if.sv
rtl/mha_sqrt_stage.sv
rtl/mha_cordic_stage.sv
rtl/matrix_heading_angle_top.sv
bench/matrix_heading_angle_checker.sv
bench/matrix_heading_angle_top_test.sv
